/* src/mips_execute_stage_assert.svh */
// ---------------------------------------------------------------------------
// mips_execute_stage_assert.svh
// Assertion macros used by the execute stage checker.
// ---------------------------------------------------------------------------
`ifndef MIPS_EXECUTE_STAGE_ASSERT_SVH
`define MIPS_EXECUTE_STAGE_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define MEXE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MEXE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mexe_pkg.sv */
// ---------------------------------------------------------------------------
// mexe_pkg
// Opcodes, function codes, memory request codes and the result record of
// the MIPS32 execute stage.
// ---------------------------------------------------------------------------
package mexe_pkg;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  // memory request codes
  localparam logic [3:0] MEM_NONE = 4'd0;
  localparam logic [3:0] MEM_LB   = 4'd1;
  localparam logic [3:0] MEM_LH   = 4'd2;
  localparam logic [3:0] MEM_LW   = 4'd3;
  localparam logic [3:0] MEM_LBU  = 4'd4;
  localparam logic [3:0] MEM_LHU  = 4'd5;
  localparam logic [3:0] MEM_SB   = 4'd6;
  localparam logic [3:0] MEM_SH   = 4'd7;
  localparam logic [3:0] MEM_SW   = 4'd8;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd31;

  typedef struct packed {
    logic        write_enable;
    logic [4:0]  write_reg;
    logic [31:0] write_value;
    logic [3:0]  mem_op;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic        redirect;
    logic [31:0] next_pc;
    logic        halt;
    logic        illegal;
  } exec_result_t;

endpackage

/* src/mips_execute_stage.sv */
// ---------------------------------------------------------------------------
// mips_execute_stage
// MIPS32 integer execute stage: writeback, memory request, redirect, halt, illegal.
// ---------------------------------------------------------------------------
// One instruction is accepted per clock while in_stall is low. Its operands
// are captured in an input register, decoded and executed in one pass, and
// the outcome is held in a result register until taken. Stall from the
// result side holds the result register and backs up into the input
// register; the input side is stalled only when both registers are full.
// Branches have no delay slot: a taken branch or jump shows redirect with
// next_pc. Arithmetic wraps and never traps.
// ---------------------------------------------------------------------------
module mips_execute_stage
  import mexe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instr,
  input  logic [31:0] pc,
  input  logic [31:0] rs_value,
  input  logic [31:0] rt_value,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_enable,
  output logic [4:0]  write_reg,
  output logic [31:0] write_value,
  output logic [3:0]  mem_op,
  output logic [31:0] mem_address,
  output logic [31:0] store_data,
  output logic        redirect,
  output logic [31:0] next_pc,
  output logic        halt,
  output logic        illegal
);

  logic         s1_valid;
  logic [31:0]  s1_instr;
  logic [31:0]  s1_pc;
  logic [31:0]  s1_rs_value;
  logic [31:0]  s1_rt_value;
  logic         res_valid;
  exec_result_t res;
  exec_result_t res_next;
  logic         res_advance;
  logic         s1_advance;

  assign res_advance = !res_valid || !out_stall;
  assign s1_advance  = !s1_valid || res_advance;
  assign in_stall    = !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && in_valid) begin
      s1_instr    <= instr;
      s1_pc       <= pc;
      s1_rs_value <= rs_value;
      s1_rt_value <= rt_value;
    end
  end

  mexe_alu u_alu (
    .instr    (s1_instr),
    .pc       (s1_pc),
    .rs_value (s1_rs_value),
    .rt_value (s1_rt_value),
    .result   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_advance && s1_valid) begin
      res <= res_next;
    end
  end

  assign out_valid    = res_valid;
  assign write_enable = res.write_enable;
  assign write_reg    = res.write_reg;
  assign write_value  = res.write_value;
  assign mem_op       = res.mem_op;
  assign mem_address  = res.mem_address;
  assign store_data   = res.store_data;
  assign redirect     = res.redirect;
  assign next_pc      = res.next_pc;
  assign halt         = res.halt;
  assign illegal      = res.illegal;

endmodule

/* src/mexe_alu.sv */
// ---------------------------------------------------------------------------
// mexe_alu
// Decode and execute of one MIPS32 integer instruction, combinational.
// ---------------------------------------------------------------------------
module mexe_alu
  import mexe_pkg::*;
(
  input  logic [31:0]  instr,
  input  logic [31:0]  pc,
  input  logic [31:0]  rs_value,
  input  logic [31:0]  rt_value,
  output exec_result_t result
);

  logic [5:0]   op;
  logic [5:0]   funct;
  logic [4:0]   rt;
  logic [4:0]   rd;
  logic [4:0]   shamt;
  logic [15:0]  imm;
  logic [31:0]  imm_zext;
  logic [31:0]  imm_sext;
  logic [31:0]  seq_pc;
  logic [31:0]  jump_target;
  logic [31:0]  branch_target;
  logic [31:0]  ea;
  logic [4:0]   sh;
  logic [31:0]  shl;
  logic [31:0]  shr;
  logic [31:0]  sar;
  logic         lt_signed;
  logic         lt_unsigned;
  logic         lti_signed;
  logic         lti_unsigned;
  exec_result_t r;

  assign op       = instr[31:26];
  assign rt       = instr[20:16];
  assign rd       = instr[15:11];
  assign shamt    = instr[10:6];
  assign funct    = instr[5:0];
  assign imm      = instr[15:0];
  assign imm_zext = {16'h0000, imm};
  assign imm_sext = {{16{imm[15]}}, imm};

  assign seq_pc        = pc + 32'd4;
  assign jump_target   = {seq_pc[31:28], instr[25:0], 2'b00};
  assign branch_target = seq_pc + {imm_sext[29:0], 2'b00};
  assign ea            = rs_value + imm_sext;

  // variable shifts have funct bit 2 set and take the amount from rs
  assign sh  = funct[2] ? rs_value[4:0] : shamt;
  assign shl = rt_value << sh;
  assign shr = rt_value >> sh;
  assign sar = 32'($signed(rt_value) >>> sh);

  assign lt_signed    = $signed(rs_value) < $signed(rt_value);
  assign lt_unsigned  = rs_value < rt_value;
  assign lti_signed   = $signed(rs_value) < $signed(imm_sext);
  assign lti_unsigned = rs_value < imm_sext;

  always_comb begin
    r = '0;
    r.write_enable = 1'b1;
    if (op == OP_SPECIAL) begin
      r.write_reg = rd;
      case (funct)
        FN_SLL, FN_SLLV: r.write_value = shl;
        FN_SRL, FN_SRLV: r.write_value = shr;
        FN_SRA, FN_SRAV: r.write_value = sar;
        FN_JR: begin
          r.write_enable = 1'b0;
          r.redirect     = 1'b1;
          r.next_pc      = rs_value;
        end
        FN_SYSCALL: begin
          r.write_enable = 1'b0;
          r.halt         = 1'b1;
        end
        FN_ADD, FN_ADDU: r.write_value = rs_value + rt_value;
        FN_SUB, FN_SUBU: r.write_value = rs_value - rt_value;
        FN_AND:          r.write_value = rs_value & rt_value;
        FN_OR:           r.write_value = rs_value | rt_value;
        FN_XOR:          r.write_value = rs_value ^ rt_value;
        FN_NOR:          r.write_value = ~(rs_value | rt_value);
        FN_SLT:          r.write_value = {31'd0, lt_signed};
        FN_SLTU:         r.write_value = {31'd0, lt_unsigned};
        default: begin
          r.write_enable = 1'b0;
          r.illegal      = 1'b1;
        end
      endcase
    end else begin
      r.write_reg = rt;
      case (op)
        OP_J: begin
          r.write_enable = 1'b0;
          r.redirect     = 1'b1;
          r.next_pc      = jump_target;
        end
        OP_JAL: begin
          r.write_reg   = REG_RA;
          r.write_value = seq_pc;
          r.redirect    = 1'b1;
          r.next_pc     = jump_target;
        end
        OP_BEQ, OP_BNE: begin
          r.write_enable = 1'b0;
          // beq takes on equal, bne on not equal
          if ((rs_value == rt_value) == (op == OP_BEQ)) begin
            r.redirect = 1'b1;
            r.next_pc  = branch_target;
          end
        end
        OP_ADDI, OP_ADDIU: r.write_value = ea;
        OP_SLTI:           r.write_value = {31'd0, lti_signed};
        OP_SLTIU:          r.write_value = {31'd0, lti_unsigned};
        OP_ANDI:           r.write_value = rs_value & imm_zext;
        OP_ORI:            r.write_value = rs_value | imm_zext;
        OP_XORI:           r.write_value = rs_value ^ imm_zext;
        OP_LUI:            r.write_value = {imm, 16'h0000};
        OP_LB:  r.mem_op = MEM_LB;
        OP_LH:  r.mem_op = MEM_LH;
        OP_LW:  r.mem_op = MEM_LW;
        OP_LBU: r.mem_op = MEM_LBU;
        OP_LHU: r.mem_op = MEM_LHU;
        OP_SB: begin
          r.write_enable = 1'b0;
          r.mem_op       = MEM_SB;
          r.store_data   = {24'd0, rt_value[7:0]};
        end
        OP_SH: begin
          r.write_enable = 1'b0;
          r.mem_op       = MEM_SH;
          r.store_data   = {16'd0, rt_value[15:0]};
        end
        OP_SW: begin
          r.write_enable = 1'b0;
          r.mem_op       = MEM_SW;
          r.store_data   = rt_value;
        end
        default: begin
          r.write_enable = 1'b0;
          r.illegal      = 1'b1;
        end
      endcase
      if (r.mem_op != MEM_NONE) begin
        r.mem_address = ea;
      end
    end

    // writes to r0 are dropped, and an unused writeback reads as zero
    if (!r.write_enable || r.write_reg == REG_ZERO) begin
      r.write_enable = 1'b0;
      r.write_reg    = REG_ZERO;
      r.write_value  = '0;
    end
  end

  assign result = r;

endmodule

/* src/mexe_checker.sv */
// ---------------------------------------------------------------------------
// mexe_checker
// Port-level checks on the execute stage result channel.
// ---------------------------------------------------------------------------
`include "mips_execute_stage_assert.svh"

module mexe_checker
  import mexe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        write_enable,
  input logic [4:0]  write_reg,
  input logic [31:0] write_value,
  input logic [3:0]  mem_op,
  input logic [31:0] mem_address,
  input logic [31:0] store_data,
  input logic        redirect,
  input logic        halt,
  input logic        illegal
);

  // a stalled transaction stays put
  `MEXE_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(write_value) &&
      $stable(mem_address) && $stable(redirect),
    "stalled result changed")

  `MEXE_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

  `MEXE_ASSERT(a_no_write_zero,
    out_valid && !write_enable |-> write_reg == REG_ZERO && write_value == 32'd0,
    "dropped writeback not zero")

  `MEXE_ASSERT(a_trap_alone,
    out_valid && (halt || illegal) |-> !redirect && !write_enable &&
      mem_op == MEM_NONE && !(halt && illegal),
    "halt or illegal with other activity")

  `MEXE_ASSERT(a_no_mem_zero,
    out_valid && mem_op == MEM_NONE |-> mem_address == 32'd0 && store_data == 32'd0,
    "memory fields set without request")

endmodule

bind mips_execute_stage mexe_checker u_mexe_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .write_enable (write_enable),
  .write_reg    (write_reg),
  .write_value  (write_value),
  .mem_op       (mem_op),
  .mem_address  (mem_address),
  .store_data   (store_data),
  .redirect     (redirect),
  .halt         (halt),
  .illegal      (illegal)
);
